// File: rtl/core/vsm_pkg.sv
// Shared types and constants for the voice sample mixer.
// Used by vsm_ctrl, vsm_datapath and voice_sample_mixer_top; no dependencies.
package vsm_pkg;

    localparam int SOURCE_SLOTS_DEF = 8;
    localparam int VOICE_SLOTS_DEF  = 16;
    localparam int FRAMES_DEF       = 4096;

    localparam int SRC_CAP_W   = 4;
    localparam int VOICE_CAP_W = 5;
    localparam int CFG_W       = 5;

    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_STOP   = 3'd2;
    localparam logic [2:0] OP_MIX    = 3'd3;
    localparam logic [2:0] OP_REINIT = 3'd4;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_INVALID     = 3'd1;
    localparam logic [2:0] ST_CAPACITY    = 3'd2;
    localparam logic [2:0] ST_BAD_GAIN    = 3'd3;
    localparam logic [2:0] ST_NO_SOURCE   = 3'd4;
    localparam logic [2:0] ST_BAD_HANDLE  = 3'd5;

    localparam logic [0:0] REG_SRC_CAP   = 1'b0;
    localparam logic [0:0] REG_VOICE_CAP = 1'b1;

    localparam logic [16:0] Q15_ONE = 17'd32768;

    typedef struct packed {
        logic latch;
        logic exec;
        logic start_wr;
        logic mix_rd;
        logic mix_mul;
        logic mix_acc;
        logic mix_fin;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       hit;
        logic       last;
    } t_stat;

endpackage

// File: rtl/core/vsm_ctrl.sv
// Controller FSM of the voice sample mixer: sequences each operation.
// Depends on vsm_pkg (t_cmd, t_stat, op codes).
module vsm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    output logic           o_done,
    output vsm_pkg::t_cmd  o_cmd,
    input  vsm_pkg::t_stat i_stat
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_EXEC     = 8'b0000_0010,
        S_START_WR = 8'b0000_0100,
        S_MIX_RD   = 8'b0000_1000,
        S_MIX_MUL  = 8'b0001_0000,
        S_MIX_ACC  = 8'b0010_0000,
        S_MIX_FIN  = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                unique case (i_stat.op)
                    vsm_pkg::OP_START: n_state = S_START_WR;
                    vsm_pkg::OP_MIX:   n_state = S_MIX_RD;
                    default:           n_state = S_DONE;
                endcase
            end
            S_START_WR: begin
                o_cmd.start_wr = 1'b1;
                n_state        = S_DONE;
            end
            S_MIX_RD: begin
                o_cmd.mix_rd = 1'b1;
                if (i_stat.hit) begin
                    n_state = S_MIX_MUL;
                end else if (i_stat.last) begin
                    n_state = S_MIX_FIN;
                end
            end
            S_MIX_MUL: begin
                o_cmd.mix_mul = 1'b1;
                n_state       = S_MIX_ACC;
            end
            S_MIX_ACC: begin
                o_cmd.mix_acc = 1'b1;
                n_state       = i_stat.last ? S_MIX_FIN : S_MIX_RD;
            end
            S_MIX_FIN: begin
                o_cmd.mix_fin = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy)
        else $error("controller did not return to idle after a result");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_done))
        else $error("accepted command did not start work");

endmodule

// File: rtl/core/vsm_datapath.sv
// Datapath of the voice sample mixer: tables, sample memory, multiply and sums.
// Depends on vsm_pkg; driven by vsm_ctrl commands.
module vsm_datapath #(
    parameter int SOURCE_SLOTS = vsm_pkg::SOURCE_SLOTS_DEF,
    parameter int VOICE_SLOTS  = vsm_pkg::VOICE_SLOTS_DEF,
    parameter int FRAMES       = vsm_pkg::FRAMES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  vsm_pkg::t_cmd                i_cmd,
    output vsm_pkg::t_stat               o_stat,
    input  logic                         i_cfg_we,
    input  logic [0:0]                   i_cfg_idx,
    input  logic [vsm_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic [2:0]                   i_op,
    input  logic signed [15:0]           i_sample_left,
    input  logic signed [15:0]           i_sample_right,
    input  logic                         i_last_frame,
    input  logic [2:0]                   i_source_slot,
    input  logic [31:0]                  i_source_generation,
    input  logic [15:0]                  i_gain,
    input  logic [3:0]                   i_voice_slot,
    input  logic [31:0]                  i_voice_generation,
    output logic [2:0]                   o_status,
    output logic signed [15:0]           o_mix_left,
    output logic signed [15:0]           o_mix_right,
    output logic [3:0]                   o_handle_slot,
    output logic [31:0]                  o_handle_generation,
    output logic [4:0]                   o_active_voices
);

    localparam int SW    = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
    localparam int VW    = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
    localparam int FCW   = $clog2(FRAMES + 1);
    localparam int DEPTH = SOURCE_SLOTS * FRAMES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(VOICE_SLOTS + 1);
    localparam int ACC_W = CW + 17;
    localparam logic [vsm_pkg::SRC_CAP_W-1:0] SRC_CAP_RST =
        (SOURCE_SLOTS < 8) ? vsm_pkg::SRC_CAP_W'(SOURCE_SLOTS) : vsm_pkg::SRC_CAP_W'(8);
    localparam logic [vsm_pkg::VOICE_CAP_W-1:0] VOICE_CAP_RST =
        (VOICE_SLOTS < 16) ? vsm_pkg::VOICE_CAP_W'(VOICE_SLOTS) : vsm_pkg::VOICE_CAP_W'(16);

    // latched command
    logic [2:0]         r_op;
    logic signed [15:0] r_sl, r_sr;
    logic               r_last;
    logic [2:0]         r_sslot;
    logic [31:0]        r_sgen;
    logic [15:0]        r_gain;
    logic [3:0]         r_vslot;
    logic [31:0]        r_vgen;

    logic [vsm_pkg::SRC_CAP_W-1:0]   r_cfg_src, r_cap_src;
    logic [vsm_pkg::VOICE_CAP_W-1:0] r_cfg_voice, r_cap_voice;
    logic [31:0]                     r_seed;

    logic [SOURCE_SLOTS-1:0] r_src_active;
    logic [FCW-1:0]          r_src_frames [SOURCE_SLOTS];
    logic [31:0]             r_mem [DEPTH];
    logic [31:0]             r_rdata;

    logic [VOICE_SLOTS-1:0] r_v_active;
    logic [SW-1:0]          r_v_sslot  [VOICE_SLOTS];
    logic [31:0]            r_v_sgen   [VOICE_SLOTS];
    logic [FCW-1:0]         r_v_cursor [VOICE_SLOTS];
    logic [16:0]            r_v_gain   [VOICE_SLOTS];
    logic [31:0]            r_v_gen    [VOICE_SLOTS];

    logic           r_load_busy;
    logic [SW-1:0]  r_load_slot;
    logic [FCW-1:0] r_load_frames;
    logic [CW-1:0]  r_vcount;
    logic [VW-1:0]  r_vidx;
    logic           r_start_ok;

    logic signed [33:0]      r_prod_l, r_prod_r;
    logic signed [ACC_W-1:0] r_acc_l, r_acc_r;

    logic [2:0]         r_status;
    logic signed [15:0] r_mixl, r_mixr;
    logic [3:0]         r_hslot;
    logic [31:0]        r_hgen;

    // combinational
    logic           src_free_found;
    logic [SW-1:0]  src_free_idx;
    logic           voice_free_found;
    logic [VW-1:0]  voice_free_idx;
    logic           src_ok_start;
    logic           cur_active;
    logic [SW-1:0]  cur_sslot;
    logic [31:0]    cur_sgen;
    logic [FCW-1:0] cur_cursor;
    logic [FCW-1:0] cur_next;
    logic [FCW-1:0] cur_n;
    logic [16:0]    cur_gain;
    logic [31:0]    cur_gen;
    logic           cur_src_ok;
    logic           cur_hit;
    logic           last_voice;
    logic [AW-1:0]  rd_addr;
    logic           ld_go;
    logic           ld_over;
    logic           ld_wr;
    logic [SW-1:0]  eff_slot;
    logic [FCW-1:0] eff_frames;
    logic [FCW-1:0] ld_next;
    logic [AW-1:0]  wr_addr;
    logic           stop_ok;
    logic [31:0]    seed_next;
    logic signed [15:0]      smp_l, smp_r;
    logic signed [17:0]      gain_s;
    logic signed [33:0]      prod_l, prod_r;
    logic signed [ACC_W-1:0] sum_l, sum_r;

    function automatic logic signed [ACC_W-1:0] q15_trunc(input logic signed [33:0] p);
        logic signed [33:0] t;
        t = p + (p[33] ? 34'sd32767 : 34'sd0);
        return ACC_W'(t >>> 15);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [15:0] r;
        if (v > ACC_W'(32767)) begin
            r = 16'sh7fff;
        end else if (v < -ACC_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

    always_comb begin
        src_free_found = 1'b0;
        src_free_idx   = '0;
        for (int i = 0; i < SOURCE_SLOTS; i++) begin
            if (!src_free_found && (i < int'(r_cap_src)) && !r_src_active[i]) begin
                src_free_found = 1'b1;
                src_free_idx   = SW'(i);
            end
        end
    end

    always_comb begin
        voice_free_found = 1'b0;
        voice_free_idx   = '0;
        for (int i = 0; i < VOICE_SLOTS; i++) begin
            if (!voice_free_found && (i < int'(r_cap_voice)) && !r_v_active[i]) begin
                voice_free_found = 1'b1;
                voice_free_idx   = VW'(i);
            end
        end
    end

    assign src_ok_start = (r_sgen != 32'd0) && (int'(r_sslot) < int'(r_cap_src)) &&
                          r_src_active[SW'(r_sslot)] && (r_sgen == r_seed);

    assign cur_active = r_v_active[r_vidx];
    assign cur_sslot  = r_v_sslot[r_vidx];
    assign cur_sgen   = r_v_sgen[r_vidx];
    assign cur_cursor = r_v_cursor[r_vidx];
    assign cur_gain   = r_v_gain[r_vidx];
    assign cur_gen    = r_v_gen[r_vidx];
    assign cur_next   = cur_cursor + FCW'(1);
    assign cur_n      = r_src_frames[cur_sslot];
    assign cur_src_ok = (cur_sgen != 32'd0) && (int'(cur_sslot) < int'(r_cap_src)) &&
                        r_src_active[cur_sslot] && (cur_sgen == r_seed);
    assign cur_hit    = cur_active && cur_src_ok && (cur_cursor < cur_n);
    assign last_voice = (int'(r_vidx) == int'(r_cap_voice) - 1);
    assign rd_addr    = AW'(cur_sslot) * AW'(FRAMES) + AW'(cur_cursor);

    assign eff_slot   = r_load_busy ? r_load_slot : src_free_idx;
    assign eff_frames = r_load_busy ? r_load_frames : '0;
    assign ld_go      = r_load_busy || src_free_found;
    assign ld_over    = (eff_frames >= FCW'(FRAMES));
    assign ld_next    = eff_frames + FCW'(1);
    assign wr_addr    = AW'(eff_slot) * AW'(FRAMES) + AW'(eff_frames);
    assign ld_wr      = i_cmd.exec && (r_op == vsm_pkg::OP_LOAD) && ld_go && !ld_over;

    assign stop_ok = (r_vgen != 32'd0) && (int'(r_vslot) < int'(r_cap_voice)) &&
                     cur_active && (cur_gen == r_vgen);

    assign seed_next = (r_seed == 32'hffff_ffff) ? 32'd1 : r_seed + 32'd1;

    assign smp_l  = r_rdata[31:16];
    assign smp_r  = r_rdata[15:0];
    assign gain_s = {1'b0, cur_gain};
    assign prod_l = smp_l * gain_s;
    assign prod_r = smp_r * gain_s;
    assign sum_l  = r_acc_l + q15_trunc(r_prod_l);
    assign sum_r  = r_acc_r + q15_trunc(r_prod_r);

    always_ff @(posedge i_clk) begin
        if (ld_wr) begin
            r_mem[wr_addr] <= {r_sl, r_sr};
        end
        if (i_cmd.mix_rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_src     <= vsm_pkg::SRC_CAP_W'(8);
            r_cfg_voice   <= vsm_pkg::VOICE_CAP_W'(16);
            r_cap_src     <= SRC_CAP_RST;
            r_cap_voice   <= VOICE_CAP_RST;
            r_seed        <= 32'd1;
            r_src_active  <= '0;
            r_v_active    <= '0;
            for (int i = 0; i < VOICE_SLOTS; i++) begin
                r_v_gen[i] <= 32'd1;
            end
            r_load_busy   <= 1'b0;
            r_load_frames <= '0;
            r_vcount      <= '0;
            r_vidx        <= '0;
            r_start_ok    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    vsm_pkg::REG_SRC_CAP:   r_cfg_src   <= i_cfg_wdata[vsm_pkg::SRC_CAP_W-1:0];
                    vsm_pkg::REG_VOICE_CAP: r_cfg_voice <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (i_cmd.latch) begin
                r_op    <= i_op;
                r_sl    <= i_sample_left;
                r_sr    <= i_sample_right;
                r_last  <= i_last_frame;
                r_sslot <= i_source_slot;
                r_sgen  <= i_source_generation;
                r_gain  <= i_gain;
                r_vslot <= i_voice_slot;
                r_vgen  <= i_voice_generation;
                r_vidx  <= (i_op == vsm_pkg::OP_STOP) ? VW'(i_voice_slot) : '0;
            end

            if (i_cmd.exec) begin
                r_status <= vsm_pkg::ST_OK;
                r_mixl   <= '0;
                r_mixr   <= '0;
                r_hslot  <= '0;
                r_hgen   <= '0;
                r_acc_l  <= '0;
                r_acc_r  <= '0;
                unique case (r_op)
                    vsm_pkg::OP_LOAD: begin
                        if (!ld_go) begin
                            r_status <= vsm_pkg::ST_CAPACITY;
                        end else if (ld_over) begin
                            r_load_busy   <= 1'b0;
                            r_load_frames <= '0;
                            r_status      <= vsm_pkg::ST_INVALID;
                        end else begin
                            r_load_slot <= eff_slot;
                            r_hslot     <= 4'(eff_slot);
                            if (r_last) begin
                                r_src_active[eff_slot] <= 1'b1;
                                r_src_frames[eff_slot] <= ld_next;
                                r_load_busy            <= 1'b0;
                                r_load_frames          <= '0;
                                r_hgen                 <= r_seed;
                            end else begin
                                r_load_busy   <= 1'b1;
                                r_load_frames <= ld_next;
                            end
                        end
                    end
                    vsm_pkg::OP_START: begin
                        r_start_ok <= 1'b0;
                        if ({1'b0, r_gain} > vsm_pkg::Q15_ONE) begin
                            r_status <= vsm_pkg::ST_BAD_GAIN;
                        end else if (!src_ok_start) begin
                            r_status <= vsm_pkg::ST_NO_SOURCE;
                        end else if (!voice_free_found) begin
                            r_status <= vsm_pkg::ST_CAPACITY;
                        end else begin
                            r_start_ok <= 1'b1;
                            r_vidx     <= voice_free_idx;
                        end
                    end
                    vsm_pkg::OP_STOP: begin
                        if (!stop_ok) begin
                            r_status <= vsm_pkg::ST_BAD_HANDLE;
                        end else begin
                            r_v_active[r_vidx] <= 1'b0;
                            r_v_cursor[r_vidx] <= '0;
                            r_v_gen[r_vidx]    <= cur_gen + 32'd1;
                            r_vcount           <= (r_vcount != '0) ? r_vcount - CW'(1) : r_vcount;
                        end
                    end
                    vsm_pkg::OP_MIX: begin
                        r_vidx <= '0;
                    end
                    vsm_pkg::OP_REINIT: begin
                        if (r_cfg_src == '0) begin
                            r_status <= vsm_pkg::ST_INVALID;
                        end else if (int'(r_cfg_src) > SOURCE_SLOTS) begin
                            r_status <= vsm_pkg::ST_CAPACITY;
                        end else if (r_cfg_voice == '0) begin
                            r_status <= vsm_pkg::ST_INVALID;
                        end else if (int'(r_cfg_voice) > VOICE_SLOTS) begin
                            r_status <= vsm_pkg::ST_CAPACITY;
                        end else begin
                            r_seed        <= seed_next;
                            r_cap_src     <= r_cfg_src;
                            r_cap_voice   <= r_cfg_voice;
                            r_src_active  <= '0;
                            r_v_active    <= '0;
                            for (int i = 0; i < VOICE_SLOTS; i++) begin
                                r_v_gen[i] <= seed_next;
                            end
                            r_load_busy   <= 1'b0;
                            r_load_frames <= '0;
                            r_vcount      <= '0;
                        end
                    end
                    default: begin
                        r_status <= vsm_pkg::ST_INVALID;
                    end
                endcase
            end

            if (i_cmd.start_wr && r_start_ok) begin
                r_v_active[r_vidx] <= 1'b1;
                r_v_sslot[r_vidx]  <= SW'(r_sslot);
                r_v_sgen[r_vidx]   <= r_sgen;
                r_v_cursor[r_vidx] <= '0;
                r_v_gain[r_vidx]   <= {1'b0, r_gain};
                r_hslot            <= 4'(r_vidx);
                r_hgen             <= cur_gen;
                r_vcount           <= r_vcount + CW'(1);
            end

            if (i_cmd.mix_rd && !cur_hit) begin
                if (cur_active) begin
                    r_v_active[r_vidx] <= 1'b0;
                    r_v_cursor[r_vidx] <= '0;
                    r_v_gen[r_vidx]    <= cur_gen + 32'd1;
                    r_vcount           <= (r_vcount != '0) ? r_vcount - CW'(1) : r_vcount;
                end
                if (!last_voice) begin
                    r_vidx <= r_vidx + VW'(1);
                end
            end

            if (i_cmd.mix_mul) begin
                r_prod_l <= prod_l;
                r_prod_r <= prod_r;
            end

            if (i_cmd.mix_acc) begin
                r_acc_l <= sum_l;
                r_acc_r <= sum_r;
                if (cur_next >= cur_n) begin
                    r_v_active[r_vidx] <= 1'b0;
                    r_v_cursor[r_vidx] <= '0;
                    r_v_gen[r_vidx]    <= cur_gen + 32'd1;
                    r_vcount           <= (r_vcount != '0) ? r_vcount - CW'(1) : r_vcount;
                end else begin
                    r_v_cursor[r_vidx] <= cur_next;
                end
                if (!last_voice) begin
                    r_vidx <= r_vidx + VW'(1);
                end
            end

            if (i_cmd.mix_fin) begin
                r_mixl <= sat16(r_acc_l);
                r_mixr <= sat16(r_acc_r);
            end
        end
    end

    assign o_stat.op   = r_op;
    assign o_stat.hit  = cur_hit;
    assign o_stat.last = last_voice;

    assign o_status            = r_status;
    assign o_mix_left          = r_mixl;
    assign o_mix_right         = r_mixr;
    assign o_handle_slot       = r_hslot;
    assign o_handle_generation = r_hgen;
    assign o_active_voices     = 5'(r_vcount);

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_v_active) == int'(r_vcount))
        else $error("voice count out of step with active voices");

    a_seed_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seed != 32'd0)
        else $error("generation seed is zero");

    a_acc_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mix_acc |-> $past(i_cmd.mix_mul))
        else $error("accumulate without a fresh product");

endmodule

// File: rtl/core/voice_sample_mixer_top.sv
// Top level of the voice sample mixer: controller plus datapath.
// Depends on vsm_pkg, vsm_ctrl and vsm_datapath.
//
// channel   | transfer                       | payload
// ----------+--------------------------------+---------------------------------------
// command   | start high while busy low      | i_op, samples, handles, i_gain
// result    | o_done high for one cycle      | o_status, o_mix_*, o_handle_*, voices
// config    | i_cfg_we high                  | i_cfg_idx, i_cfg_wdata
//
// One command at a time; busy stays high from acceptance until the result cycle.
// Load, stop, reinitialize and unused ops: execute, then result. Start voice adds a
// voice-table write. Mix: read, multiply and accumulate per playing voice, a read
// per other slot, then saturate; the single multiply/accumulate path walks the voice table in order.
// Synchronous active-low reset; the sample memory needs no clearing pass.
module voice_sample_mixer_top #(
    parameter int SOURCE_SLOTS = vsm_pkg::SOURCE_SLOTS_DEF,
    parameter int VOICE_SLOTS  = vsm_pkg::VOICE_SLOTS_DEF,
    parameter int FRAMES       = vsm_pkg::FRAMES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    output logic                      o_done,
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_idx,
    input  logic [vsm_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic [2:0]                i_op,
    input  logic signed [15:0]        i_sample_left,
    input  logic signed [15:0]        i_sample_right,
    input  logic                      i_last_frame,
    input  logic [2:0]                i_source_slot,
    input  logic [31:0]               i_source_generation,
    input  logic [15:0]               i_gain,
    input  logic [3:0]                i_voice_slot,
    input  logic [31:0]               i_voice_generation,
    output logic [2:0]                o_status,
    output logic signed [15:0]        o_mix_left,
    output logic signed [15:0]        o_mix_right,
    output logic [3:0]                o_handle_slot,
    output logic [31:0]               o_handle_generation,
    output logic [4:0]                o_active_voices
);

    vsm_pkg::t_cmd  cmd;
    vsm_pkg::t_stat stat;

    vsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    vsm_datapath #(
        .SOURCE_SLOTS (SOURCE_SLOTS),
        .VOICE_SLOTS  (VOICE_SLOTS),
        .FRAMES       (FRAMES)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_op                (i_op),
        .i_sample_left       (i_sample_left),
        .i_sample_right      (i_sample_right),
        .i_last_frame        (i_last_frame),
        .i_source_slot       (i_source_slot),
        .i_source_generation (i_source_generation),
        .i_gain              (i_gain),
        .i_voice_slot        (i_voice_slot),
        .i_voice_generation  (i_voice_generation),
        .o_status            (o_status),
        .o_mix_left          (o_mix_left),
        .o_mix_right         (o_mix_right),
        .o_handle_slot       (o_handle_slot),
        .o_handle_generation (o_handle_generation),
        .o_active_voices     (o_active_voices)
    );

endmodule

// File: tb/vsm_checker.sv
// Checker for the voice sample mixer: tracks source and voice tables, predicts each result.
// Watches the command, config and result ports of voice_sample_mixer_top; uses vsm_pkg.
`timescale 1ns / 1ps
module vsm_checker
    import vsm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               o_done,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  logic [2:0]         i_op,
    input  logic signed [15:0] i_sample_left,
    input  logic signed [15:0] i_sample_right,
    input  logic               i_last_frame,
    input  logic [2:0]         i_source_slot,
    input  logic [31:0]        i_source_generation,
    input  logic [15:0]        i_gain,
    input  logic [3:0]         i_voice_slot,
    input  logic [31:0]        i_voice_generation,
    input  logic [2:0]         o_status,
    input  logic signed [15:0] o_mix_left,
    input  logic signed [15:0] o_mix_right,
    input  logic [3:0]         o_handle_slot,
    input  logic [31:0]        o_handle_generation,
    input  logic [4:0]         o_active_voices,
    output int                 o_fail_cnt,
    output int                 o_pending
);

    localparam int NSRC = SOURCE_SLOTS_DEF;
    localparam int NVOI = VOICE_SLOTS_DEF;
    localparam int NFRM = FRAMES_DEF;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [15:0] mix_l;
        logic signed [15:0] mix_r;
        logic [3:0]         hslot;
        logic [31:0]        hgen;
        logic [4:0]         nvoices;
    } t_mix_result;

    t_mix_result result_q[$];

    logic [3:0]  src_cap_reg;
    logic [4:0]  voice_cap_reg;
    int          src_cap, voice_cap;
    logic [31:0] seed;
    bit          src_live [NSRC];
    int          src_len [NSRC];
    logic [31:0] frame_mem [int];
    bit          v_live [NVOI];
    int          v_src [NVOI];
    logic [31:0] v_src_gen [NVOI];
    int          v_pos [NVOI];
    int          v_gain [NVOI];
    logic [31:0] v_gen [NVOI];
    bit          filling;
    int          fill_slot, fill_len;
    int          nvoices;

    function automatic void clear_tables();
        for (int i = 0; i < NSRC; i++) begin
            src_live[i] = 0;
            src_len[i]  = 0;
        end
        for (int i = 0; i < NVOI; i++) begin
            v_live[i]    = 0;
            v_src[i]     = 0;
            v_src_gen[i] = 0;
            v_pos[i]     = 0;
            v_gain[i]    = 0;
            v_gen[i]     = seed;
        end
        filling   = 0;
        fill_slot = 0;
        fill_len  = 0;
        nvoices   = 0;
    endfunction

    function automatic bit source_valid(int slot, logic [31:0] gen);
        return gen != 0 && slot < src_cap && src_live[slot] && gen == seed;
    endfunction

    function automatic void halt_voice(int v);
        v_live[v] = 0;
        v_pos[v]  = 0;
        v_gen[v]  = v_gen[v] + 32'd1;
        if (nvoices > 0) nvoices--;
    endfunction

    function automatic int scaled(logic [15:0] raw, int g);
        int s;
        s = int'($signed(raw));
        return (s * g) / 32768;
    endfunction

    function automatic logic signed [15:0] clip16(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic t_mix_result mixer_step();
        t_mix_result r;
        int          i, idx, suml, sumr;
        bit          go;
        logic [31:0] word;
        r = '0;
        case (i_op)
            OP_LOAD: begin
                go = 1;
                if (!filling) begin
                    for (i = 0; i < src_cap; i++) if (!src_live[i]) break;
                    if (i >= src_cap) begin
                        r.status = ST_CAPACITY;
                        go = 0;
                    end else begin
                        filling   = 1;
                        fill_slot = i;
                        fill_len  = 0;
                    end
                end
                if (go && fill_len >= NFRM) begin
                    filling  = 0;
                    fill_len = 0;
                    r.status = ST_INVALID;
                    go = 0;
                end
                if (go) begin
                    frame_mem[fill_slot * NFRM + fill_len] = {i_sample_left, i_sample_right};
                    fill_len++;
                    r.hslot = fill_slot[3:0];
                    if (i_last_frame) begin
                        src_live[fill_slot] = 1;
                        src_len[fill_slot]  = fill_len;
                        filling  = 0;
                        fill_len = 0;
                        r.hgen   = seed;
                    end
                end
            end
            OP_START: begin
                if ({1'b0, i_gain} > Q15_ONE) begin
                    r.status = ST_BAD_GAIN;
                end else if (!source_valid(int'(i_source_slot), i_source_generation)) begin
                    r.status = ST_NO_SOURCE;
                end else begin
                    for (i = 0; i < voice_cap; i++) if (!v_live[i]) break;
                    if (i >= voice_cap) begin
                        r.status = ST_CAPACITY;
                    end else begin
                        v_live[i]    = 1;
                        v_src[i]     = int'(i_source_slot);
                        v_src_gen[i] = i_source_generation;
                        v_pos[i]     = 0;
                        v_gain[i]    = int'(i_gain);
                        r.hslot      = i[3:0];
                        r.hgen       = v_gen[i];
                        nvoices++;
                    end
                end
            end
            OP_STOP: begin
                if (i_voice_generation == 0 || i_voice_slot >= voice_cap ||
                    !v_live[i_voice_slot] || v_gen[i_voice_slot] != i_voice_generation)
                    r.status = ST_BAD_HANDLE;
                else
                    halt_voice(int'(i_voice_slot));
            end
            OP_MIX: begin
                suml = 0;
                sumr = 0;
                for (i = 0; i < voice_cap; i++) begin
                    if (!v_live[i]) continue;
                    if (!source_valid(v_src[i], v_src_gen[i]) || v_pos[i] >= src_len[v_src[i]])
                    begin
                        halt_voice(i);
                        continue;
                    end
                    idx  = v_src[i] * NFRM + v_pos[i];
                    word = frame_mem[idx];
                    suml += scaled(word[31:16], v_gain[i]);
                    sumr += scaled(word[15:0], v_gain[i]);
                    v_pos[i]++;
                    if (v_pos[i] >= src_len[v_src[i]]) halt_voice(i);
                end
                r.mix_l = clip16(suml);
                r.mix_r = clip16(sumr);
            end
            OP_REINIT: begin
                if (src_cap_reg == 0) r.status = ST_INVALID;
                else if (src_cap_reg > NSRC) r.status = ST_CAPACITY;
                else if (voice_cap_reg == 0) r.status = ST_INVALID;
                else if (voice_cap_reg > NVOI) r.status = ST_CAPACITY;
                else begin
                    seed = seed + 32'd1;
                    if (seed == 0) seed = 32'd1;
                    src_cap   = int'(src_cap_reg);
                    voice_cap = int'(voice_cap_reg);
                    clear_tables();
                end
            end
            default: r.status = ST_INVALID;
        endcase
        r.nvoices = nvoices[4:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_mix_result got, want;
        if (!i_rst_n) begin
            src_cap_reg   = 4'd8;
            voice_cap_reg = 5'd16;
            src_cap       = NSRC;
            voice_cap     = NVOI;
            seed          = 32'd1;
            frame_mem.delete();
            clear_tables();
            result_q.delete();
            o_fail_cnt = 0;
        end else begin
            if (o_done) begin
                got = {o_status, o_mix_left, o_mix_right, o_handle_slot,
                       o_handle_generation, o_active_voices};
                if (result_q.size() == 0) begin
                    o_fail_cnt++;
                    if (o_fail_cnt <= 10) $display("unexpected result transfer: %p", got);
                end else begin
                    want = result_q.pop_front();
                    if (got !== want) begin
                        o_fail_cnt++;
                        if (o_fail_cnt <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (start && !busy) result_q.push_back(mixer_step());
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_SRC_CAP) src_cap_reg = i_cfg_wdata[3:0];
                else voice_cap_reg = i_cfg_wdata;
            end
        end
        o_pending = result_q.size();
    end

endmodule

// File: tb/tb_top.sv
// Testbench top for voice_sample_mixer_top: clock, reset, command stimulus and verdict.
// Depends on vsm_pkg, voice_sample_mixer_top and vsm_checker.
`timescale 1ns / 1ps
module tb_top;
    import vsm_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic               i_clk, i_rst_n, start, i_cfg_we, i_last_frame;
    logic               busy, o_done;
    logic [0:0]         i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_wdata;
    logic [2:0]         i_op, i_source_slot, o_status;
    logic signed [15:0] i_sample_left, i_sample_right, o_mix_left, o_mix_right;
    logic [31:0]        i_source_generation, i_voice_generation, o_handle_generation;
    logic [15:0]        i_gain;
    logic [3:0]         i_voice_slot, o_handle_slot;
    logic [4:0]         o_active_voices;
    int                 fail_cnt, pending, idle_cycles;

    logic [2:0]  issued_ops[$];
    logic [35:0] src_handles[$];
    logic [35:0] voice_handles[$];

    voice_sample_mixer_top dut (.*);

    vsm_checker u_checker (.*, .o_fail_cnt(fail_cnt), .o_pending(pending));

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // learn live handles from results so that stimulus can reuse them
    always @(posedge i_clk) begin
        logic [2:0] op;
        if (i_rst_n && o_done && issued_ops.size() > 0) begin
            op = issued_ops.pop_front();
            if (o_status == ST_OK && o_handle_generation != 0) begin
                if (op == OP_LOAD) src_handles.push_back({o_handle_slot, o_handle_generation});
                if (op == OP_START) voice_handles.push_back({o_handle_slot, o_handle_generation});
                if (src_handles.size() > 8) void'(src_handles.pop_front());
                if (voice_handles.size() > 16) void'(voice_handles.pop_front());
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic randomize_fields();
        i_sample_left       = 16'($urandom);
        i_sample_right      = 16'($urandom);
        i_last_frame        = 1'($urandom);
        i_source_slot       = 3'($urandom);
        i_source_generation = $urandom;
        i_gain              = 16'($urandom);
        i_voice_slot        = 4'($urandom);
        i_voice_generation  = $urandom;
    endtask

    // fields already set; hold start until the transfer happens
    task automatic issue(input logic [2:0] op, input bit no_gap = 0);
        if (!no_gap) repeat (gap_len()) @(negedge i_clk);
        i_op  = op;
        start = 1;
        while (busy) @(negedge i_clk);
        issued_ops.push_back(op);
        @(negedge i_clk);
        start = 0;
    endtask

    task automatic drain();
        while (pending != 0 || start) @(negedge i_clk);
    endtask

    task automatic load_frame(input logic [15:0] l, input logic [15:0] r, input bit last);
        randomize_fields();
        i_sample_left  = l;
        i_sample_right = r;
        i_last_frame   = last;
        issue(OP_LOAD);
    endtask

    task automatic start_voice(input logic [2:0] slot, input logic [31:0] gen,
                               input logic [15:0] g);
        randomize_fields();
        i_source_slot       = slot;
        i_source_generation = gen;
        i_gain              = g;
        issue(OP_START);
    endtask

    task automatic stop_voice(input logic [3:0] slot, input logic [31:0] gen);
        randomize_fields();
        i_voice_slot       = slot;
        i_voice_generation = gen;
        issue(OP_STOP);
    endtask

    task automatic plain_op(input logic [2:0] op);
        randomize_fields();
        issue(op);
    endtask

    task automatic cfg_write(input logic [0:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1;
        i_cfg_idx   = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic random_gain(output logic [15:0] g);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) g = 16'd32768;
        else if (r < 14) g = 16'($urandom_range(32769, 65535));
        else if (r < 18) g = 16'd0;
        else g = 16'($urandom_range(0, 32768));
    endtask

    task automatic random_item();
        int          r, n, k;
        logic [35:0] h;
        logic [15:0] g;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            n = $urandom_range(1, 5);
            for (k = 0; k < n; k++)
                load_frame(16'($urandom), 16'($urandom),
                           k == n - 1 ? ($urandom_range(0, 9) != 0) : 1'b0);
        end else if (r < 47) begin
            random_gain(g);
            if (src_handles.size() > 0 && $urandom_range(0, 9) < 8) begin
                h = src_handles[$urandom_range(0, src_handles.size() - 1)];
                start_voice(h[34:32], h[31:0], g);
            end else begin
                start_voice(3'($urandom), $urandom_range(0, 3) == 0 ? 32'd0 : $urandom, g);
            end
        end else if (r < 58) begin
            if (voice_handles.size() > 0 && $urandom_range(0, 9) < 8) begin
                h = voice_handles[$urandom_range(0, voice_handles.size() - 1)];
                stop_voice(h[35:32], h[31:0]);
            end else begin
                stop_voice(4'($urandom), $urandom_range(0, 3) == 0 ? 32'd0 : $urandom);
            end
        end else if (r < 92) begin
            plain_op(OP_MIX);
        end else if (r < 94) begin
            plain_op(OP_REINIT);
        end else if (r < 97) begin
            plain_op(3'($urandom_range(5, 7)));
        end else begin
            plain_op(OP_LOAD);
        end
    endtask

    initial begin
        logic [35:0] h;
        logic [4:0]  phase_cfg [9][2];
        phase_cfg = '{'{5'd1, 5'd1}, '{5'd0, 5'd16}, '{5'd9, 5'd16}, '{5'd8, 5'd0},
                      '{5'd8, 5'd17}, '{5'd15, 5'd31}, '{5'd3, 5'd4}, '{5'd2, 5'd9},
                      '{5'd8, 5'd16}};
        i_rst_n = 0;
        start = 0;
        i_cfg_we = 0;
        i_cfg_idx = REG_SRC_CAP;
        i_cfg_wdata = '0;
        i_op = OP_MIX;
        randomize_fields();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1;

        // directed: extremes, every op, error paths
        load_frame(16'h7FFF, 16'h8000, 1);
        load_frame(16'hFFFF, 16'h0000, 0);
        load_frame(16'h5555, 16'hAAAA, 1);
        drain();
        h = src_handles[0];
        start_voice(h[34:32], h[31:0], 16'd32768);
        start_voice(h[34:32], h[31:0], 16'd32769);
        start_voice(h[34:32], 32'd0, 16'd100);
        start_voice(3'd7, 32'd1, 16'd100);
        start_voice(h[34:32], h[31:0] + 32'd1, 16'd100);
        h = src_handles[1];
        start_voice(h[34:32], h[31:0], 16'hFFFF);
        start_voice(h[34:32], h[31:0], 16'd0);
        start_voice(h[34:32], h[31:0], 16'd32768);
        plain_op(OP_MIX);
        plain_op(OP_MIX);
        drain();
        h = voice_handles[voice_handles.size() - 1];
        stop_voice(h[35:32], 32'd0);
        stop_voice(h[35:32], h[31:0]);
        stop_voice(h[35:32], h[31:0]);
        stop_voice(4'd15, 32'hFFFF_FFFF);
        plain_op(OP_MIX);
        plain_op(3'd5);
        plain_op(3'd6);
        plain_op(3'd7);
        plain_op(OP_REINIT);
        load_frame(16'h1234, 16'hEDCB, 1);

        foreach (phase_cfg[p]) begin
            drain();
            cfg_write(REG_SRC_CAP, phase_cfg[p][0]);
            cfg_write(REG_VOICE_CAP, phase_cfg[p][1]);
            plain_op(OP_REINIT);
            for (int n = 0; n < 52; n++) begin
                random_item();
                if (n == 26) drain();
            end
        end

        drain();
        repeat (100) @(negedge i_clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
